@@ sv/sbr_pkg.sv @@
// shared types and constants of the supersample box reduce block
package sbr_pkg;

  localparam int MAX_SAMPLE_DEF    = 8;
  localparam int MAX_OUT_WIDTH_DEF = 1024;
  localparam int HEIGHT_LIMIT      = 4096;
  localparam int ROW_W             = 12;
  localparam int SF_W              = 4;
  localparam int OW_W              = 11;
  localparam int OH_W              = 13;
  localparam int PADDR_W           = 4;
  localparam int PDATA_W           = 32;
  localparam int QUO_W             = 8;
  localparam int STEP_W            = 3;
  localparam int HITS_W            = 32;

  localparam logic [1:0] REG_SAMPLE = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic [7:0]        red_in;
    logic [7:0]        green_in;
    logic [7:0]        blue_in;
    logic [HITS_W-1:0] hits_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]        red_out;
    logic [7:0]        green_out;
    logic [7:0]        blue_out;
    logic [HITS_W-1:0] hits_out;
    logic              row_end;
    logic              frame_end;
  } pix_out_t;

  typedef struct packed {
    logic accept;
    logic upd;
    logic div_step;
    logic emit;
  } sbr_cmd_t;

  typedef struct packed {
    logic last_blk;
    logic div_last;
    logic out_free;
  } sbr_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } sbr_state_t;

endpackage

@@ sv/sbr_ctrl.sv @@
// controller state machine of the supersample box reduce block
module sbr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbr_pkg::sbr_stat_t  stat,
  output sbr_pkg::sbr_cmd_t   cmd
);

  sbr_pkg::sbr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      sbr_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sbr_pkg::ST_UPD;
        end
      end
      sbr_pkg::ST_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = stat.last_blk ? sbr_pkg::ST_DIV : sbr_pkg::ST_IDLE;
      end
      sbr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = sbr_pkg::ST_EMIT;
        end
      end
      sbr_pkg::ST_EMIT: begin
        // wait until the output register is free or being taken
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sbr_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == sbr_pkg::ST_IDLE);

endmodule

@@ sv/sbr_datapath.sv @@
// position counters, line store, mean divider and output register
module sbr_datapath #(
  parameter int MAX_SAMPLE    = sbr_pkg::MAX_SAMPLE_DEF,
  parameter int MAX_OUT_WIDTH = sbr_pkg::MAX_OUT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [sbr_pkg::SF_W-1:0]   sample_factor,
  input  logic [sbr_pkg::OW_W-1:0]   out_width,
  input  logic [sbr_pkg::OH_W-1:0]   out_height,
  input  logic                       restart,
  input  sbr_pkg::sbr_cmd_t          cmd,
  output sbr_pkg::sbr_stat_t         stat,
  input  sbr_pkg::pix_in_t           in_data,
  output sbr_pkg::pix_out_t          out_data,
  output logic                       out_valid,
  input  logic                       out_ready
);

  localparam int SW    = (MAX_SAMPLE > 1) ? $clog2(MAX_SAMPLE) : 1;
  localparam int SEW   = $clog2(MAX_SAMPLE + 1);
  localparam int CW    = $clog2(MAX_OUT_WIDTH);
  localparam int WEW   = $clog2(MAX_OUT_WIDTH + 1);
  localparam int AW    = $clog2(MAX_SAMPLE * MAX_SAMPLE + 1);
  localparam int CSW   = $clog2(MAX_SAMPLE * MAX_SAMPLE * 255 + 1);
  localparam int DVW   = CSW + sbr_pkg::QUO_W;
  localparam int HW    = sbr_pkg::HITS_W;
  localparam int ENT_W = 3 * CSW + HW;
  localparam int HEW   = sbr_pkg::ROW_W + 1;

  // effective register values
  logic [SEW-1:0] s_eff;
  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  logic [AW-1:0]  area;

  always_comb begin
    if (sample_factor == '0) begin
      s_eff = SEW'(1);
    end else if (int'(sample_factor) > MAX_SAMPLE) begin
      s_eff = SEW'(MAX_SAMPLE);
    end else begin
      s_eff = SEW'(sample_factor);
    end
    if (out_width == '0) begin
      w_eff = WEW'(1);
    end else if (int'(out_width) > MAX_OUT_WIDTH) begin
      w_eff = WEW'(MAX_OUT_WIDTH);
    end else begin
      w_eff = WEW'(out_width);
    end
    if (out_height == '0) begin
      h_eff = HEW'(1);
    end else if (int'(out_height) > sbr_pkg::HEIGHT_LIMIT) begin
      h_eff = HEW'(sbr_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = HEW'(out_height);
    end
    area = AW'({{AW{1'b0}}, s_eff} * {{AW{1'b0}}, s_eff});
  end

  // position counters
  logic [CW-1:0]               col_r, col_nxt;
  logic [SW-1:0]               subc_r, subc_nxt;
  logic [SW-1:0]               subr_r, subr_nxt;
  logic [sbr_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic                        subc_last, subr_last, col_last, row_last, first_pix;

  assign subc_last = (SEW'(subc_r) == (s_eff - SEW'(1)));
  assign subr_last = (SEW'(subr_r) == (s_eff - SEW'(1)));
  assign col_last  = (WEW'(col_r) == (w_eff - WEW'(1)));
  assign row_last  = ({1'b0, row_r} == (h_eff - HEW'(1)));
  assign first_pix = (subc_r == '0) && (subr_r == '0);

  always_comb begin
    col_nxt  = col_r;
    subc_nxt = subc_r;
    subr_nxt = subr_r;
    row_nxt  = row_r;
    if (restart) begin
      col_nxt  = '0;
      subc_nxt = '0;
      subr_nxt = '0;
      row_nxt  = '0;
    end else if (cmd.accept) begin
      if (subc_last) begin
        subc_nxt = '0;
        if (col_last) begin
          col_nxt = '0;
          if (subr_last) begin
            subr_nxt = '0;
            row_nxt  = row_last ? '0 : row_r + 1'b1;
          end else begin
            subr_nxt = subr_r + 1'b1;
          end
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end else begin
        subc_nxt = subc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      subc_r <= '0;
      subr_r <= '0;
      row_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      subc_r <= subc_nxt;
      subr_r <= subr_nxt;
      row_r  <= row_nxt;
    end
  end

  // item held for the update cycle
  sbr_pkg::pix_in_t pix_r;
  logic [CW-1:0]    addr_r;
  logic             first_r, last_r, row_end_r, frame_end_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r       <= in_data;
      addr_r      <= col_r;
      first_r     <= first_pix;
      last_r      <= subc_last && subr_last;
      row_end_r   <= col_last;
      frame_end_r <= col_last && row_last;
    end
  end

  // line store: read at transfer, written back in the following cycle
  logic [ENT_W-1:0] mem [MAX_OUT_WIDTH];
  logic [ENT_W-1:0] rd_r;
  logic [ENT_W-1:0] upd_ent;
  logic [CSW-1:0]   red_sum, green_sum, blue_sum;
  logic [HW-1:0]    hit_sum;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_r <= mem[col_r];
    end
    if (cmd.upd) begin
      mem[addr_r] <= upd_ent;
    end
  end

  always_comb begin
    if (first_r) begin
      red_sum   = CSW'(pix_r.red_in);
      green_sum = CSW'(pix_r.green_in);
      blue_sum  = CSW'(pix_r.blue_in);
      hit_sum   = pix_r.hits_in;
    end else begin
      red_sum   = rd_r[ENT_W-1 -: CSW] + CSW'(pix_r.red_in);
      green_sum = rd_r[ENT_W-CSW-1 -: CSW] + CSW'(pix_r.green_in);
      blue_sum  = rd_r[HW+CSW-1 -: CSW] + CSW'(pix_r.blue_in);
      hit_sum   = rd_r[HW-1:0] + pix_r.hits_in;
    end
    upd_ent = {red_sum, green_sum, blue_sum, hit_sum};
  end

  // restoring divider, one quotient bit per step on all three colors
  logic [DVW-1:0]            rem_r [3];
  logic [sbr_pkg::QUO_W-1:0] quo_r [3];
  logic [DVW-1:0]            den_r;
  logic [sbr_pkg::STEP_W-1:0] step_r;
  logic [HW-1:0]             hits_r;
  logic                      row_end_d_r, frame_end_d_r;

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      rem_r[0]      <= DVW'(red_sum);
      rem_r[1]      <= DVW'(green_sum);
      rem_r[2]      <= DVW'(blue_sum);
      den_r         <= DVW'(area) << (sbr_pkg::QUO_W - 1);
      step_r        <= '0;
      hits_r        <= hit_sum;
      row_end_d_r   <= row_end_r;
      frame_end_d_r <= frame_end_r;
    end else if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        if (rem_r[i] >= den_r) begin
          rem_r[i] <= rem_r[i] - den_r;
          quo_r[i] <= {quo_r[i][sbr_pkg::QUO_W-2:0], 1'b1};
        end else begin
          quo_r[i] <= {quo_r[i][sbr_pkg::QUO_W-2:0], 1'b0};
        end
      end
      den_r  <= den_r >> 1;
      step_r <= step_r + 1'b1;
    end
  end

  // output register
  logic              out_valid_r;
  sbr_pkg::pix_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.red_out   <= quo_r[0];
      out_data_r.green_out <= quo_r[1];
      out_data_r.blue_out  <= quo_r[2];
      out_data_r.hits_out  <= hits_r;
      out_data_r.row_end   <= row_end_d_r;
      out_data_r.frame_end <= frame_end_d_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.last_blk = last_r;
  assign stat.div_last = (step_r == sbr_pkg::STEP_W'(sbr_pkg::QUO_W - 1));
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

@@ sv/supersample_box_reduce_core.sv @@
// top level: register port, controller and datapath of the box reduce block
// a pixel that does not finish a block goes through transfer, then line store update
// a pixel that finishes a block goes through transfer, update, 8 divider steps, output load
// the result shows on out_valid once the output load registers it, after the divider steps
// the line store read-modify-write holds off a new pixel until the previous one is written back
// reset: sample_factor 1, out_width 1024, out_height 1024, position zero; line store not cleared
module supersample_box_reduce_core #(
  parameter int MAX_SAMPLE    = sbr_pkg::MAX_SAMPLE_DEF,
  parameter int MAX_OUT_WIDTH = sbr_pkg::MAX_OUT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sbr_pkg::pix_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sbr_pkg::pix_out_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbr_pkg::PADDR_W-1:0]   paddr,
  input  logic [sbr_pkg::PDATA_W-1:0]   pwdata,
  output logic [sbr_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [sbr_pkg::SF_W-1:0] sample_factor_r;
  logic [sbr_pkg::OW_W-1:0] out_width_r;
  logic [sbr_pkg::OH_W-1:0] out_height_r;
  logic                     wr_en;
  logic [1:0]               reg_idx;
  logic                     restart;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign restart = wr_en && ((reg_idx == sbr_pkg::REG_SAMPLE) ||
                             (reg_idx == sbr_pkg::REG_WIDTH) ||
                             (reg_idx == sbr_pkg::REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_factor_r <= sbr_pkg::SF_W'(1);
      out_width_r     <= sbr_pkg::OW_W'(1024);
      out_height_r    <= sbr_pkg::OH_W'(1024);
    end else if (wr_en) begin
      unique case (reg_idx)
        sbr_pkg::REG_SAMPLE: sample_factor_r <= pwdata[sbr_pkg::SF_W-1:0];
        sbr_pkg::REG_WIDTH:  out_width_r     <= pwdata[sbr_pkg::OW_W-1:0];
        sbr_pkg::REG_HEIGHT: out_height_r    <= pwdata[sbr_pkg::OH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sbr_pkg::REG_SAMPLE: prdata = sbr_pkg::PDATA_W'(sample_factor_r);
      sbr_pkg::REG_WIDTH:  prdata = sbr_pkg::PDATA_W'(out_width_r);
      sbr_pkg::REG_HEIGHT: prdata = sbr_pkg::PDATA_W'(out_height_r);
      default:             prdata = '0;
    endcase
  end

  sbr_pkg::sbr_cmd_t  cmd;
  sbr_pkg::sbr_stat_t stat;

  sbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sbr_datapath #(
    .MAX_SAMPLE    (MAX_SAMPLE),
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .sample_factor (sample_factor_r),
    .out_width     (out_width_r),
    .out_height    (out_height_r),
    .restart       (restart),
    .cmd           (cmd),
    .stat          (stat),
    .in_data       (in_data),
    .out_data      (out_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready)
  );

  // the line store write-back always comes in the cycle after an input transfer
  a_upd_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> $past(in_valid && in_ready))
    else $error("line store update without a preceding input transfer");

  // no new input is taken while the store update is in flight
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken during line store update");

  // a fresh result only appears after a load from the divider
  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result appeared without a load");

  // the output register is loaded only when it is empty or its previous result leaves
  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

endmodule
